FILE: hw/rtl/parallel_port_interface_core_macros.svh
// Assertion macros for the parallel port interface core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PARALLEL_PORT_INTERFACE_CORE_MACROS_SVH
`define PARALLEL_PORT_INTERFACE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, masked while reset is high.
`define PPI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock edge, active during reset as well.
`define PPI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PPI_ASSERT(label, clk, rst, prop, msg)
`define PPI_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/ppi_pkg.sv
// Shared types and constants for the parallel port interface core.
// No dependencies; used by ppi_exec and parallel_port_interface_core.
package ppi_pkg;

   // Access kind.
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Port selection codes.
   typedef enum logic [1:0] {
      PORT_A    = 2'd0,
      PORT_B    = 2'd1,
      PORT_C    = 2'd2,
      PORT_CTRL = 2'd3
   } port_sel_type;

   // Control word fields.
   localparam logic [7:0] CW_RESET   = 8'h9b;
   localparam logic [7:0] CW_AMODE   = 8'h60;
   localparam logic [7:0] CW_A_IN    = 8'h10;
   localparam logic [7:0] CW_CHI_IN  = 8'h08;
   localparam logic [7:0] CW_BMODE   = 8'h04;
   localparam logic [7:0] CW_B_IN    = 8'h02;
   localparam logic [7:0] CW_CLO_IN  = 8'h01;
   localparam logic [7:0] CW_MODESET = 8'h80;
   localparam logic [7:0] BSR_BITSEL = 8'h07;
   localparam logic [7:0] READ_ONES  = 8'hff;

   typedef struct packed {
      logic         kind;
      port_sel_type port_index;
      logic [7:0]   write_data;
      logic [7:0]   pins_a;
      logic [7:0]   pins_b;
      logic [3:0]   pins_c_low;
      logic [3:0]   pins_c_high;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] drive_a;
      logic       strobe_a;
      logic [7:0] drive_b;
      logic       strobe_b;
      logic [3:0] drive_c_low;
      logic       strobe_c_low;
      logic [3:0] drive_c_high;
      logic       strobe_c_high;
   } rsp_type;

   typedef struct packed {
      logic [7:0] latch_a;
      logic [7:0] latch_b;
      logic [7:0] latch_c;
      logic [7:0] ctrl;
   } regs_type;

endpackage

FILE: hw/rtl/ppi_exec.sv
// Combinational access logic: read mux, port drive and next register state.
// Depends on ppi_pkg.
module ppi_exec (
   input  ppi_pkg::req_type  req,
   input  ppi_pkg::regs_type cur,
   output ppi_pkg::rsp_type  rsp,
   output ppi_pkg::regs_type nxt
);

   logic       is_write;
   logic       modeset;
   logic [7:0] ctrl_eff;
   logic [7:0] bsr_mask;
   logic [7:0] bsr_value;
   logic [7:0] rd_value;
   logic       sel_a;
   logic       sel_b;
   logic       sel_c;
   logic [2:0] bsr_bit;

   assign is_write = (req.kind == ppi_pkg::KIND_WRITE);
   assign modeset  = is_write && (req.port_index == ppi_pkg::PORT_CTRL)
                     && ((req.write_data & ppi_pkg::CW_MODESET) != 8'h00);
   assign ctrl_eff = modeset ? req.write_data : cur.ctrl;

   // Bit set/reset of one port C bit.
   assign bsr_bit   = 3'((req.write_data >> 1) & ppi_pkg::BSR_BITSEL);
   assign bsr_mask  = 8'(8'h01 << bsr_bit);
   assign bsr_value = req.write_data[0] ? (cur.latch_c | bsr_mask)
                                        : (cur.latch_c & ~bsr_mask);

   // Read mux.
   always_comb begin
      rd_value = cur.ctrl;
      unique case (req.port_index)
         ppi_pkg::PORT_A: begin
            if ((cur.ctrl & ppi_pkg::CW_AMODE) != 8'h00) begin
               rd_value = ppi_pkg::READ_ONES;
            end else if ((cur.ctrl & ppi_pkg::CW_A_IN) != 8'h00) begin
               rd_value = req.pins_a;
            end else begin
               rd_value = cur.latch_a;
            end
         end
         ppi_pkg::PORT_B: begin
            if ((cur.ctrl & ppi_pkg::CW_BMODE) != 8'h00) begin
               rd_value = ppi_pkg::READ_ONES;
            end else if ((cur.ctrl & ppi_pkg::CW_B_IN) != 8'h00) begin
               rd_value = req.pins_b;
            end else begin
               rd_value = cur.latch_b;
            end
         end
         ppi_pkg::PORT_C: begin
            rd_value[3:0] = ((cur.ctrl & ppi_pkg::CW_CLO_IN) != 8'h00)
                            ? req.pins_c_low : cur.latch_c[3:0];
            rd_value[7:4] = ((cur.ctrl & ppi_pkg::CW_CHI_IN) != 8'h00)
                            ? req.pins_c_high : cur.latch_c[7:4];
         end
         ppi_pkg::PORT_CTRL: begin
            rd_value = cur.ctrl;
         end
         default: begin
            rd_value = cur.ctrl;
         end
      endcase
   end

   // Next register state and which ports get driven.
   always_comb begin
      nxt   = cur;
      sel_a = 1'b0;
      sel_b = 1'b0;
      sel_c = 1'b0;
      if (is_write) begin
         unique case (req.port_index)
            ppi_pkg::PORT_A: begin
               nxt.latch_a = req.write_data;
               sel_a       = 1'b1;
            end
            ppi_pkg::PORT_B: begin
               nxt.latch_b = req.write_data;
               sel_b       = 1'b1;
            end
            ppi_pkg::PORT_C: begin
               nxt.latch_c = req.write_data;
               sel_c       = 1'b1;
            end
            ppi_pkg::PORT_CTRL: begin
               if (modeset) begin
                  nxt.ctrl = req.write_data;
                  sel_a    = 1'b1;
                  sel_b    = 1'b1;
                  sel_c    = 1'b1;
               end else begin
                  nxt.latch_c = bsr_value;
                  sel_c       = 1'b1;
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

   // Drive outputs use the direction bits in force after this access.
   always_comb begin
      rsp               = '0;
      rsp.read_data     = is_write ? 8'h00 : rd_value;
      rsp.strobe_a      = sel_a && ((ctrl_eff & ppi_pkg::CW_A_IN) == 8'h00);
      rsp.strobe_b      = sel_b && ((ctrl_eff & ppi_pkg::CW_B_IN) == 8'h00);
      rsp.strobe_c_low  = sel_c && ((ctrl_eff & ppi_pkg::CW_CLO_IN) == 8'h00);
      rsp.strobe_c_high = sel_c && ((ctrl_eff & ppi_pkg::CW_CHI_IN) == 8'h00);
      rsp.drive_a       = rsp.strobe_a ? nxt.latch_a : 8'h00;
      rsp.drive_b       = rsp.strobe_b ? nxt.latch_b : 8'h00;
      rsp.drive_c_low   = rsp.strobe_c_low ? nxt.latch_c[3:0] : 4'h0;
      rsp.drive_c_high  = rsp.strobe_c_high ? nxt.latch_c[7:4] : 4'h0;
   end

endmodule

FILE: hw/rtl/parallel_port_interface_core.sv
// Three-port parallel interface core (basic I/O and handshake-mode reads), bus side.
// An accepted word sits in the input register, then its result goes to the result register.
// Throughput: one word per cycle while the consumer does not stall the result register.
// Reset (synchronous, active high): latches clear to 0, control word loads 0x9b (all input),
// both pipeline registers empty. Depends on ppi_pkg, ppi_exec and the macros header.
`include "parallel_port_interface_core_macros.svh"

module parallel_port_interface_core (
   input  logic       clock,
   input  logic       reset,
   // Request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [1:0] req_port_index,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_pins_a,
   input  logic [7:0] req_pins_b,
   input  logic [3:0] req_pins_c_low,
   input  logic [3:0] req_pins_c_high,
   // Response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_drive_a,
   output logic       rsp_strobe_a,
   output logic [7:0] rsp_drive_b,
   output logic       rsp_strobe_b,
   output logic [3:0] rsp_drive_c_low,
   output logic       rsp_strobe_c_low,
   output logic [3:0] rsp_drive_c_high,
   output logic       rsp_strobe_c_high
);

   // Input register: holds one accepted word until it can move on.
   logic              in_valid_ff;
   logic              in_valid_in;
   ppi_pkg::req_type  in_word_ff;
   ppi_pkg::req_type  in_word_in;

   // Result register: holds one finished word until the consumer takes it.
   logic              out_valid_ff;
   logic              out_valid_in;
   ppi_pkg::rsp_type  out_word_ff;
   ppi_pkg::rsp_type  out_word_in;

   // Architectural state: three port latches and the control word.
   ppi_pkg::regs_type regs_ff;
   ppi_pkg::regs_type regs_in;

   ppi_pkg::rsp_type  exec_rsp;
   ppi_pkg::regs_type exec_regs;

   logic              advance;
   logic              req_take;

   // Advance the input word into the result register when that register is
   // empty or is being drained this cycle. State commits only on advance, so
   // accesses act on the latches strictly in acceptance order.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Stall the requester only while a word is stuck in the input register.
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ppi_exec u_exec (
      .req (in_word_ff),
      .cur (regs_ff),
      .rsp (exec_rsp),
      .nxt (exec_regs)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      regs_in      = regs_ff;

      // Drop the result once the consumer has taken it.
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      // Drop the input word when it moves on.
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_word_in  = exec_rsp;
         regs_in      = exec_regs;
      end
      // Capture a new word; the input register is free whenever req_stall is low.
      if (req_take) begin
         in_valid_in = 1'b1;
         in_word_in  = '{kind:        req_kind,
                         port_index:  ppi_pkg::port_sel_type'(req_port_index),
                         write_data:  req_write_data,
                         pins_a:      req_pins_a,
                         pins_b:      req_pins_b,
                         pins_c_low:  req_pins_c_low,
                         pins_c_high: req_pins_c_high};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         regs_ff.latch_a <= 8'h00;
         regs_ff.latch_b <= 8'h00;
         regs_ff.latch_c <= 8'h00;
         regs_ff.ctrl    <= ppi_pkg::CW_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         regs_ff      <= regs_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_word_ff.read_data;
   assign rsp_drive_a       = out_word_ff.drive_a;
   assign rsp_strobe_a      = out_word_ff.strobe_a;
   assign rsp_drive_b       = out_word_ff.drive_b;
   assign rsp_strobe_b      = out_word_ff.strobe_b;
   assign rsp_drive_c_low   = out_word_ff.drive_c_low;
   assign rsp_strobe_c_low  = out_word_ff.strobe_c_low;
   assign rsp_drive_c_high  = out_word_ff.drive_c_high;
   assign rsp_strobe_c_high = out_word_ff.strobe_c_high;

   // Reset empties the pipeline and loads the default control word.
   `PPI_ASSERT_ALWAYS(a_reset_state, clock,
      reset |=> (!out_valid_ff && !in_valid_ff && regs_ff.ctrl == ppi_pkg::CW_RESET),
      "reset did not restore pipeline and control word")

   // A read never drives any port.
   `PPI_ASSERT(a_read_no_drive, clock, reset,
      (advance && in_word_ff.kind == ppi_pkg::KIND_READ) |=>
         (!rsp_strobe_a && !rsp_strobe_b && !rsp_strobe_c_low && !rsp_strobe_c_high),
      "read access drove a port")

   // State holds while the word in the input register is blocked.
   `PPI_ASSERT(a_state_hold, clock, reset,
      (in_valid_ff && out_valid_ff && rsp_stall) |=> $stable(regs_ff),
      "register state changed while access was blocked")

   // A mode-set write loads the control word.
   `PPI_ASSERT(a_mode_set, clock, reset,
      (advance && in_word_ff.kind == ppi_pkg::KIND_WRITE
         && in_word_ff.port_index == ppi_pkg::PORT_CTRL && in_word_ff.write_data[7])
         |=> (regs_ff.ctrl == $past(in_word_ff.write_data)),
      "mode set did not load control word")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for parallel_port_interface_core: a directed table of bus words,
// then random words, each result checked against a hand-typed word or an in-bench predictor.
// Depends on ppi_pkg and the core RTL only.
module tb_top;

   localparam int RANDOM_WORDS  = 500;
   localparam int IDLE_LIMIT    = 2000;  // cycles with no handshake on either channel
   localparam int SETTLE_CYCLES = 4;     // wait after the final drain, with margin
   localparam int CALM_FIRST    = 100;   // random words sent with no idling on either side
   localparam int CALM_LAST     = 199;
   localparam int DRAIN_AT      = 250;   // random word before which the sender waits for results

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_kind;
   logic [1:0] req_port_index;
   logic [7:0] req_write_data;
   logic [7:0] req_pins_a;
   logic [7:0] req_pins_b;
   logic [3:0] req_pins_c_low;
   logic [3:0] req_pins_c_high;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_read_data;
   logic [7:0] rsp_drive_a;
   logic       rsp_strobe_a;
   logic [7:0] rsp_drive_b;
   logic       rsp_strobe_b;
   logic [3:0] rsp_drive_c_low;
   logic       rsp_strobe_c_low;
   logic [3:0] rsp_drive_c_high;
   logic       rsp_strobe_c_high;

   // One row of the directed table: the bus word, and a hand-typed result where it is obvious.
   typedef struct {
      ppi_pkg::req_type word;
      bit               typed;
      ppi_pkg::rsp_type want;
   } stim_row_type;

   // Predictor state: the three port latches and the control word.
   logic [7:0]       port_latch [3];
   logic [7:0]       ctrl_word;

   ppi_pkg::rsp_type pending_rsp [$];  // expected result words, oldest first
   stim_row_type     stim_table [$];
   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   bit               calm_phase     = 1'b0;

   parallel_port_interface_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_port_index    (req_port_index),
      .req_write_data    (req_write_data),
      .req_pins_a        (req_pins_a),
      .req_pins_b        (req_pins_b),
      .req_pins_c_low    (req_pins_c_low),
      .req_pins_c_high   (req_pins_c_high),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_data     (rsp_read_data),
      .rsp_drive_a       (rsp_drive_a),
      .rsp_strobe_a      (rsp_strobe_a),
      .rsp_drive_b       (rsp_drive_b),
      .rsp_strobe_b      (rsp_strobe_b),
      .rsp_drive_c_low   (rsp_drive_c_low),
      .rsp_strobe_c_low  (rsp_strobe_c_low),
      .rsp_drive_c_high  (rsp_drive_c_high),
      .rsp_strobe_c_high (rsp_strobe_c_high)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Store a latch and drive the port, or each port C nibble, whose direction is output.
   function automatic ppi_pkg::rsp_type latch_and_drive(logic [1:0] p, logic [7:0] v,
                                                        ppi_pkg::rsp_type r);
      port_latch[p] = v;
      case (p)
         2'd0: if ((ctrl_word & ppi_pkg::CW_A_IN) == 8'h00) begin
            r.drive_a  = v;
            r.strobe_a = 1'b1;
         end
         2'd1: if ((ctrl_word & ppi_pkg::CW_B_IN) == 8'h00) begin
            r.drive_b  = v;
            r.strobe_b = 1'b1;
         end
         default: begin
            if ((ctrl_word & ppi_pkg::CW_CLO_IN) == 8'h00) begin
               r.drive_c_low  = v[3:0];
               r.strobe_c_low = 1'b1;
            end
            if ((ctrl_word & ppi_pkg::CW_CHI_IN) == 8'h00) begin
               r.drive_c_high  = v[7:4];
               r.strobe_c_high = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   // Work out the result of one bus word and advance the latches and control word.
   function automatic ppi_pkg::rsp_type predict_access(ppi_pkg::req_type w);
      ppi_pkg::rsp_type r;
      logic [7:0]       c_next;
      r = '0;
      if (w.kind == ppi_pkg::KIND_READ) begin
         case (w.port_index)
            // Handshake modes hide the A and B pins behind all ones.
            ppi_pkg::PORT_A: begin
               if ((ctrl_word & ppi_pkg::CW_AMODE) != 8'h00) r.read_data = ppi_pkg::READ_ONES;
               else if ((ctrl_word & ppi_pkg::CW_A_IN) != 8'h00) r.read_data = w.pins_a;
               else r.read_data = port_latch[0];
            end
            ppi_pkg::PORT_B: begin
               if ((ctrl_word & ppi_pkg::CW_BMODE) != 8'h00) r.read_data = ppi_pkg::READ_ONES;
               else if ((ctrl_word & ppi_pkg::CW_B_IN) != 8'h00) r.read_data = w.pins_b;
               else r.read_data = port_latch[1];
            end
            // Port C mixes latch and pins per nibble, mode bits play no part.
            ppi_pkg::PORT_C: begin
               r.read_data = port_latch[2];
               if ((ctrl_word & ppi_pkg::CW_CLO_IN) != 8'h00) r.read_data[3:0] = w.pins_c_low;
               if ((ctrl_word & ppi_pkg::CW_CHI_IN) != 8'h00) r.read_data[7:4] = w.pins_c_high;
            end
            default: r.read_data = ctrl_word;
         endcase
      end else if (w.port_index != ppi_pkg::PORT_CTRL) begin
         r = latch_and_drive(w.port_index, w.write_data, r);
      end else if ((w.write_data & ppi_pkg::CW_MODESET) != 8'h00) begin
         // Mode set keeps the latches and re-drives every port that is now output.
         ctrl_word = w.write_data;
         r = latch_and_drive(2'd0, port_latch[0], r);
         r = latch_and_drive(2'd1, port_latch[1], r);
         r = latch_and_drive(2'd2, port_latch[2], r);
      end else begin
         // Bit set/reset: bits 3..1 pick the port C bit, bit 0 is its new value.
         c_next = port_latch[2];
         c_next[w.write_data[3:1]] = w.write_data[0];
         r = latch_and_drive(2'd2, c_next, r);
      end
      return r;
   endfunction

   function automatic ppi_pkg::req_type bus_word(logic kind, ppi_pkg::port_sel_type p,
                                                 logic [7:0] d,
                                                 logic [7:0] pa, logic [7:0] pb,
                                                 logic [3:0] pcl, logic [3:0] pch);
      ppi_pkg::req_type w;
      w.kind        = kind;
      w.port_index  = p;
      w.write_data  = d;
      w.pins_a      = pa;
      w.pins_b      = pb;
      w.pins_c_low  = pcl;
      w.pins_c_high = pch;
      return w;
   endfunction

   // Build a result word; stb holds the strobes of A, B, C low and C high, in that order.
   function automatic ppi_pkg::rsp_type outs(logic [7:0] rd, logic [7:0] da, logic [7:0] db,
                                             logic [3:0] cl, logic [3:0] ch, logic [3:0] stb);
      ppi_pkg::rsp_type r;
      r.read_data     = rd;
      r.drive_a       = da;
      r.strobe_a      = stb[3];
      r.drive_b       = db;
      r.strobe_b      = stb[2];
      r.drive_c_low   = cl;
      r.strobe_c_low  = stb[1];
      r.drive_c_high  = ch;
      r.strobe_c_high = stb[0];
      return r;
   endfunction

   task automatic add_row(ppi_pkg::req_type w, bit typed, ppi_pkg::rsp_type want);
      stim_row_type row;
      row.word  = w;
      row.typed = typed;
      row.want  = want;
      stim_table.push_back(row);
   endtask

   // Present one word at the falling edge, hold it until accepted, then queue its result.
   // The predictor always runs so that its state follows the block, typed row or not.
   task automatic send_access(ppi_pkg::req_type w, bit typed, ppi_pkg::rsp_type want);
      ppi_pkg::rsp_type predicted;
      while (!calm_phase && $urandom_range(99) < 38) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_kind        <= w.kind;
      req_port_index  <= w.port_index;
      req_write_data  <= w.write_data;
      req_pins_a      <= w.pins_a;
      req_pins_b      <= w.pins_b;
      req_pins_c_low  <= w.pins_c_low;
      req_pins_c_high <= w.pins_c_high;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_access(w);
      pending_rsp.push_back(typed ? want : predicted);
   endtask

   // Drop valid and hold until every queued result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: stall at random on the falling edge, except in the calm stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !calm_phase && ($urandom_range(99) < 38);
      end
   end

   // Compare each accepted result word with the oldest expectation, field by field.
   always @(posedge clock) begin : rsp_check
      ppi_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result word with no expectation waiting");
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("read_data", want.read_data, rsp_read_data);
            check_field("drive_a", want.drive_a, rsp_drive_a);
            check_field("strobe_a", 8'(want.strobe_a), 8'(rsp_strobe_a));
            check_field("drive_b", want.drive_b, rsp_drive_b);
            check_field("strobe_b", 8'(want.strobe_b), 8'(rsp_strobe_b));
            check_field("drive_c_low", 8'(want.drive_c_low), 8'(rsp_drive_c_low));
            check_field("strobe_c_low", 8'(want.strobe_c_low), 8'(rsp_strobe_c_low));
            check_field("drive_c_high", 8'(want.drive_c_high), 8'(rsp_drive_c_high));
            check_field("strobe_c_high", 8'(want.strobe_c_high), 8'(rsp_strobe_c_high));
         end
      end
   end

   // Watchdog: end the run when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      ppi_pkg::req_type w;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = ppi_pkg::KIND_READ;
      req_port_index  = ppi_pkg::PORT_A;
      req_write_data  = '0;
      req_pins_a      = '0;
      req_pins_b      = '0;
      req_pins_c_low  = '0;
      req_pins_c_high = '0;
      port_latch[0]   = '0;
      port_latch[1]   = '0;
      port_latch[2]   = '0;
      ctrl_word       = ppi_pkg::CW_RESET;

      // Directed table. After reset every port is input in basic mode.
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_CTRL, 8'h00, 8'h5a, 8'ha5, 4'h3,
                       4'hc), 1'b1,
              outs(ppi_pkg::CW_RESET, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_A, 8'h00, 8'hff, 8'h00, 4'h0, 4'h0),
              1'b1, outs(8'hff, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_B, 8'hff, 8'hff, 8'h00, 4'hf, 4'hf),
              1'b1, outs(8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_C, 8'h00, 8'h00, 8'hff, 4'hf, 4'h0),
              1'b1, outs(8'h0f, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      // Write of an input port: latch only, nothing driven.
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'hff, 8'h00, 8'h00, 4'h0, 4'h0),
              1'b1, outs(8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      // Mode set to all output: latches kept and driven.
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h80, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b1,
              outs(8'h00, 8'hff, 8'h00, 4'h0, 4'h0, 4'b1111));
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_A, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0),
              1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_B, 8'ha5, 8'h12, 8'h34, 4'h5, 4'h6),
              1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, 8'h3c, 8'h12, 8'h34, 4'h5, 4'h6),
              1'b0, '0);
      // Bit set/reset: set C7, clear C0, set C0 with the ignored bits high, set C7 again.
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h0f, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h00, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h71, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h7f, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_C, 8'h00, 8'hff, 8'hff, 4'hf, 4'hf),
              1'b0, '0);
      // Handshake modes on both groups, A and both C nibbles output, B input.
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'he6, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_A, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0),
              1'b1, outs(ppi_pkg::READ_ONES, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_B, 8'h00, 8'h00, 8'h00, 4'h0, 4'h0),
              1'b1, outs(ppi_pkg::READ_ONES, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_A, 8'h12, 8'h00, 8'h00, 4'h0, 4'h0),
              1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_C, 8'h00, 8'h00, 8'h00, 4'h9, 4'h9),
              1'b0, '0);
      // Both C nibbles input: a read returns the pins.
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'h89, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b0, '0);
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_C, 8'h00, 8'h00, 8'h00, 4'h5, 4'ha),
              1'b1, outs(8'ha5, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      // Control word all ones: everything input, handshake modes, nothing driven.
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, 8'hff, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b1,
              outs(8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_READ, ppi_pkg::PORT_CTRL, 8'h00, 8'h00, 8'h00, 4'h0,
                       4'h0), 1'b1,
              outs(8'hff, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_C, 8'h00, 8'hff, 8'hff, 4'hf, 4'hf),
              1'b1, outs(8'h00, 8'h00, 8'h00, 4'h0, 4'h0, 4'b0000));
      add_row(bus_word(ppi_pkg::KIND_WRITE, ppi_pkg::PORT_CTRL, ppi_pkg::CW_RESET, 8'h00,
                       8'h00, 4'h0, 4'h0), 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) send_access(stim_table[i].word, stim_table[i].typed,
                                          stim_table[i].want);
      drain_results();

      // Random words: about one in eight is a control write, half of those a mode set.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm_phase = (n >= CALM_FIRST) && (n <= CALM_LAST);
         if (n == DRAIN_AT) drain_results();
         w.kind        = 1'($urandom_range(1));
         w.port_index  = ppi_pkg::port_sel_type'(2'($urandom_range(3)));
         w.write_data  = 8'($urandom);
         w.pins_a      = 8'($urandom);
         w.pins_b      = 8'($urandom);
         w.pins_c_low  = 4'($urandom);
         w.pins_c_high = 4'($urandom);
         send_access(w, 1'b0, '0);
      end
      calm_phase = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: parallel_port_interface_core.f
+incdir+hw/rtl
hw/rtl/ppi_pkg.sv
hw/rtl/ppi_exec.sv
hw/rtl/parallel_port_interface_core.sv
tb/sv/tb_top.sv
